/* rtl/pfd_pkg.sv */
`default_nettype none

package pfd_pkg;

    // key square geometry
    localparam int SIDE     = 5;
    localparam int CELLS    = 25;
    localparam int ALPHA    = 26;
    localparam int LETTER_I = 8;
    localparam int LETTER_J = 9;

    // ascii codes
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [6:0] PLAIN_BASE    = 7'h41;

    // item kind carried on the input channel
    typedef enum logic {
        ACT_KEY    = 1'b0,
        ACT_CIPHER = 1'b1
    } action_t;

    // classified item passed from front to back
    typedef struct packed {
        action_t    action;
        logic       is_letter;
        logic [4:0] idx;
        logic       key_last;
    } item_t;

endpackage

`default_nettype wire

/* rtl/playfair_digraph_decrypt_top.sv */
// Playfair digraph decryption over a 5x5 key square.
// Input channel (in_valid/in_stall): each beat carries action, letter and
// key_last. Key beats (action 0) build the square; the beat with key_last
// set starts a fill of the remaining letters that walks the alphabet once.
// A key beat after a finished key starts a new square.
// Cipher beats (action 1) are paired; spaces and other non-letters among them
// are dropped at the front.
// Output channel (out_valid/out_stall): the second letter of each pair gives
// two beats, plain_letter with last_of_run 0, then with last_of_run 1.
// After the second cipher letter of a pair is accepted, the back end reads the
// positions, reads the square, passes a wait state and loads the two output
// beats in turn; a single key letter is placed as it is popped.
// A queue of QUEUE_DEPTH beats sits between the classifier and the back end;
// in_stall rises only when it is full. When the receiver stalls, the output
// beat holds and the back end waits, while the queue keeps taking input.
// Reset clears the key, any open pair and the queue; the square memories
// are not cleared and are read only after a key is finished.
`default_nettype none

module playfair_digraph_decrypt_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [7:0]  letter,
    input  wire logic        key_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [6:0]       plain_letter,
    output logic             last_of_run
);
    import pfd_pkg::*;

    item_t front_item;
    item_t head_item;
    logic  front_keep;
    logic  q_full;
    logic  q_not_empty;
    logic  q_pop;
    logic  q_push;

    // classify incoming beats
    pfd_front u_front (
        .action   (action),
        .letter   (letter),
        .key_last (key_last),
        .item     (front_item),
        .keep     (front_keep)
    );

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && front_keep;

    // decoupling queue
    pfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (head_item),
        .not_empty (q_not_empty)
    );

    // key building and pair decryption
    pfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_not_empty),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .plain_letter (plain_letter),
        .last_of_run  (last_of_run)
    );

`ifndef NO_ASSERTIONS
    // output letters are upper case and never j
    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (plain_letter >= 7'h41) && (plain_letter <= 7'h5A)
                      && (plain_letter != 7'h4A))
        else $error("plain letter out of range");

    // the second letter of a pair follows its first at once
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid && last_of_run)
        else $error("second letter of pair missing");

    // the queue never pops while empty
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* rtl/pfd_front.sv */
`default_nettype none

module pfd_front (
    input  wire logic        action,
    input  wire logic [7:0]  letter,
    input  wire logic        key_last,
    output pfd_pkg::item_t   item,
    output logic             keep
);
    import pfd_pkg::*;

    logic       is_letter;
    logic [7:0] offset;
    logic [4:0] raw_idx;

    // letter detection, either case
    always_comb
    begin
        is_letter = 1'b0;
        offset    = '0;
        if (letter inside {[ASCII_UPPER_A:ASCII_UPPER_Z]})
        begin
            is_letter = 1'b1;
            offset    = letter - ASCII_UPPER_A;
        end
        else if (letter inside {[ASCII_LOWER_A:ASCII_LOWER_Z]})
        begin
            is_letter = 1'b1;
            offset    = letter - ASCII_LOWER_A;
        end
    end

    assign raw_idx = offset[4:0];

    // fold j onto i and build the item
    always_comb
    begin
        item.action    = action_t'(action);
        item.is_letter = is_letter;
        item.idx       = (raw_idx == 5'(LETTER_J)) ? 5'(LETTER_I) : raw_idx;
        item.key_last  = key_last;
    end

    // cipher non-letters (spaces included) have no effect at all
    assign keep = (action_t'(action) == ACT_KEY) || is_letter;

endmodule

`default_nettype wire

/* rtl/pfd_queue.sv */
`default_nettype none

module pfd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire pfd_pkg::item_t  push_item,
    output logic                 full,
    input  wire logic            pop,
    output pfd_pkg::item_t       pop_item,
    output logic                 not_empty
);
    import pfd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           slots [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slots[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/pfd_back.sv */
`default_nettype none

module pfd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire pfd_pkg::item_t  q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [6:0]           plain_letter,
    output logic                 last_of_run
);
    import pfd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_POS,
        S_SQ,
        S_EMIT1,
        S_EMIT2
    } state_t;

    // square memories: letter per cell, {row,col} per letter
    logic [4:0] sq_mem  [CELLS];
    logic [5:0] pos_mem [ALPHA];

    state_t      state_reg, state_next;
    logic [25:0] used_reg, used_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [2:0]  row_reg, row_next;
    logic [2:0]  col_reg, col_next;
    logic        done_reg, done_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [4:0]  pend_letter_reg, pend_letter_next;
    logic [4:0]  sweep_reg, sweep_next;
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  out_letter_reg, out_letter_next;
    logic        out_last_reg, out_last_next;

    logic        clear;
    logic        place_en;
    logic [4:0]  place_idx;
    logic [25:0] base_used;
    logic [4:0]  base_cnt;
    logic [2:0]  base_row;
    logic [2:0]  base_col;
    logic        wr_en;

    logic        pos_rd_en;
    logic [4:0]  pos_addr_a, pos_addr_b;
    logic [5:0]  pos_a_q, pos_b_q;
    logic        sq_rd_en;
    logic [4:0]  sq_addr_a, sq_addr_b;
    logic [4:0]  sq_a_q, sq_b_q;

    logic [2:0]  r1, c1, r2, c2;
    logic [2:0]  ra, ca, rb, cb;
    logic        slot_free;

    function automatic logic [2:0] wrap_dec(input logic [2:0] v);
        wrap_dec = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
    endfunction

    function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
        cell_addr = ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
    endfunction

    assign slot_free = !out_valid_reg || !out_stall;

    assign r1 = pos_a_q[5:3];
    assign c1 = pos_a_q[2:0];
    assign r2 = pos_b_q[5:3];
    assign c2 = pos_b_q[2:0];

    // decryption rules on the two looked-up positions
    always_comb
    begin
        if (r1 == r2)
        begin
            ra = r1;
            ca = wrap_dec(c1);
            rb = r2;
            cb = wrap_dec(c2);
        end
        else if (c1 == c2)
        begin
            ra = wrap_dec(r1);
            ca = c1;
            rb = wrap_dec(r2);
            cb = c2;
        end
        else
        begin
            ra = r1;
            ca = c2;
            rb = r2;
            cb = c1;
        end
    end

    assign sq_addr_a = cell_addr(ra, ca);
    assign sq_addr_b = cell_addr(rb, cb);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        done_next        = done_reg;
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        sweep_next       = sweep_reg;
        out_valid_next   = out_valid_reg;
        out_letter_next  = out_letter_reg;
        out_last_next    = out_last_reg;
        clear            = 1'b0;
        place_en         = 1'b0;
        place_idx        = '0;
        q_pop            = 1'b0;
        pos_rd_en        = 1'b0;
        pos_addr_a       = pend_letter_reg;
        pos_addr_b       = q_item.idx;
        sq_rd_en         = 1'b0;

        if (slot_free)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.action == ACT_KEY)
                    begin
                        // a key after a finished key starts over
                        if (done_reg)
                        begin
                            clear            = 1'b1;
                            done_next        = 1'b0;
                            pend_valid_next  = 1'b0;
                            pend_letter_next = '0;
                        end
                        place_en  = q_item.is_letter;
                        place_idx = q_item.idx;
                        if (q_item.key_last)
                        begin
                            sweep_next = '0;
                            state_next = S_FILL;
                        end
                    end
                    else if (done_reg)
                    begin
                        if (!pend_valid_reg)
                        begin
                            pend_valid_next  = 1'b1;
                            pend_letter_next = q_item.idx;
                        end
                        else
                        begin
                            pos_rd_en        = 1'b1;
                            pend_valid_next  = 1'b0;
                            pend_letter_next = '0;
                            state_next       = S_POS;
                        end
                    end
                end
            end
            S_FILL:
            begin
                // walk the alphabet once, skipping j
                place_en   = (sweep_reg != 5'(LETTER_J));
                place_idx  = sweep_reg;
                sweep_next = sweep_reg + 5'd1;
                if (sweep_reg == 5'(ALPHA - 1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POS:
            begin
                sq_rd_en   = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                state_next = S_EMIT1;
            end
            S_EMIT1:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_letter_next = PLAIN_BASE + {2'b00, sq_a_q};
                    out_last_next   = 1'b0;
                    state_next      = S_EMIT2;
                end
            end
            S_EMIT2:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_letter_next = PLAIN_BASE + {2'b00, sq_b_q};
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // letter placement into the next free cell
    always_comb
    begin
        base_used = clear ? '0 : used_reg;
        base_cnt  = clear ? '0 : cnt_reg;
        base_row  = clear ? '0 : row_reg;
        base_col  = clear ? '0 : col_reg;
        wr_en     = place_en && !base_used[place_idx] && (base_cnt < 5'(CELLS));
        used_next = base_used;
        cnt_next  = base_cnt;
        row_next  = base_row;
        col_next  = base_col;
        if (wr_en)
        begin
            used_next[place_idx] = 1'b1;
            cnt_next = base_cnt + 5'd1;
            if (base_col == 3'(SIDE - 1))
            begin
                col_next = '0;
                row_next = base_row + 3'd1;
            end
            else
            begin
                col_next = base_col + 3'd1;
            end
        end
    end

    // square memories
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sq_mem[base_cnt]   <= place_idx;
            pos_mem[place_idx] <= {base_row, base_col};
        end
        if (pos_rd_en)
        begin
            pos_a_q <= pos_mem[pos_addr_a];
            pos_b_q <= pos_mem[pos_addr_b];
        end
        if (sq_rd_en)
        begin
            sq_a_q <= sq_mem[sq_addr_a];
            sq_b_q <= sq_mem[sq_addr_b];
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            used_reg        <= '0;
            cnt_reg         <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            done_reg        <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
            sweep_reg       <= '0;
            out_valid_reg   <= 1'b0;
            out_letter_reg  <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            cnt_reg         <= cnt_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            done_reg        <= done_next;
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
            sweep_reg       <= sweep_next;
            out_valid_reg   <= out_valid_next;
            out_letter_reg  <= out_letter_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign plain_letter = out_letter_reg;
    assign last_of_run  = out_last_reg;

endmodule

`default_nettype wire
